>>> design/linear_adsr_envelope_macros.svh
// Assertion macros shared by the envelope generator modules.
`ifndef LINEAR_ADSR_ENVELOPE_MACROS_SVH
`define LINEAR_ADSR_ENVELOPE_MACROS_SVH

// Condition that must hold at every clock edge out of reset.
`define LAE_ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define LAE_ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LAE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/lae_pkg.sv
// Shared widths and the divider request type of the envelope generator.
package lae_pkg;

    localparam int SEG_W  = 23;            // segment length in ticks
    localparam int STEP_W = 17;            // Q1.16 level and step size
    localparam int NUM_W  = 32;            // divider dividend width
    localparam int CNT_W  = 6;             // divider step counter
    localparam int PROD_W = SEG_W + STEP_W;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] steps;
    } t_div_req;

endpackage

>>> design/lae_mul.sv
// Bit-serial shift-add multiplier, one multiplier bit per cycle, LSB first.
`include "linear_adsr_envelope_macros.svh"

module lae_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [lae_pkg::STEP_W-1:0]  i_mcand,
    input  logic [lae_pkg::SEG_W-1:0]   i_mplier,
    output logic                        o_done,
    output logic [lae_pkg::PROD_W-1:0]  o_product
);

    localparam int MUL_CW = $clog2(lae_pkg::SEG_W + 1);

    logic                       r_busy;
    logic                       r_done;
    logic [MUL_CW-1:0]          r_cnt;
    logic [lae_pkg::STEP_W-1:0] r_mcand;
    logic [lae_pkg::STEP_W-1:0] r_acc;
    logic [lae_pkg::SEG_W-1:0]  r_sr;
    logic [lae_pkg::STEP_W:0]   n_sum;

    assign n_sum = {1'b0, r_acc} + (r_sr[0] ? {1'b0, r_mcand} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy  <= 1'b1;
                r_cnt   <= MUL_CW'(lae_pkg::SEG_W);
                r_mcand <= i_mcand;
                r_acc   <= '0;
                r_sr    <= i_mplier;
            end else if (r_busy) begin
                // Low product bits leave the accumulator into the vacated multiplier bits.
                r_acc <= n_sum[lae_pkg::STEP_W:1];
                r_sr  <= {n_sum[0], r_sr[lae_pkg::SEG_W-1:1]};
                r_cnt <= r_cnt - MUL_CW'(1);
                if (r_cnt == MUL_CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done    = r_done;
    assign o_product = {r_acc, r_sr};

    `LAE_ASSERT_IMPLY(a_acc_bound, i_clk, i_rst_n, r_busy, r_acc < r_mcand || r_mcand == '0, "multiplier accumulator outgrew the multiplicand")

endmodule

>>> design/lae_div.sv
// Bit-serial restoring divider, one quotient bit per cycle, dividend MSB first.
`include "linear_adsr_envelope_macros.svh"

module lae_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  lae_pkg::t_div_req          i_req,
    input  logic [lae_pkg::NUM_W-1:0]  i_num,
    input  logic [lae_pkg::SEG_W-1:0]  i_den,
    output logic                       o_done,
    output logic [lae_pkg::NUM_W-1:0]  o_quo
);

    logic                        r_busy;
    logic                        r_done;
    logic [lae_pkg::CNT_W-1:0]   r_cnt;
    logic [lae_pkg::NUM_W-1:0]   r_num;
    logic [lae_pkg::SEG_W-1:0]   r_den;
    logic [lae_pkg::SEG_W-1:0]   r_rem;
    logic [lae_pkg::NUM_W-1:0]   r_quo;
    logic [lae_pkg::SEG_W:0]     n_trial;
    logic [lae_pkg::SEG_W:0]     n_diff;
    logic                        n_fits;

    assign n_trial = {r_rem, r_num[lae_pkg::NUM_W-1]};
    assign n_diff  = n_trial - {1'b0, r_den};
    assign n_fits  = n_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
                r_num  <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
                r_quo  <= '0;
            end else if (r_busy) begin
                r_rem <= n_fits ? n_diff[lae_pkg::SEG_W-1:0] : n_trial[lae_pkg::SEG_W-1:0];
                r_num <= {r_num[lae_pkg::NUM_W-2:0], 1'b0};
                r_quo <= {r_quo[lae_pkg::NUM_W-2:0], n_fits};
                r_cnt <= r_cnt - lae_pkg::CNT_W'(1);
                if (r_cnt == lae_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

    `LAE_ASSERT_IMPLY(a_rem_below_den, i_clk, i_rst_n, r_busy && r_den != '0, r_rem < r_den, "partial remainder reached the divisor")

endmodule

>>> design/linear_adsr_envelope.sv
// Linear ADSR envelope generator: tick sequencer, config registers, output register.
// A held or silent tick runs the bit-serial multiplier once, for velocity; a ramping tick runs it
// once for the ramp and once for velocity.
// A note start adds three multiply and divide pairs for segment lengths, then the sustain and step
// divisions; a release start adds one 17-step division, skipped for a zero-length release.
// Reset is synchronous; it restores the register defaults and the idle envelope.
`include "linear_adsr_envelope_macros.svh"

module linear_adsr_envelope #(
    parameter int TICK_WIDTH = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_trigger_level,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [16:0] o_envelope_level,
    output logic [23:0] o_scaled_level,
    output logic [1:0]  o_phase,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam int SINCE_W  = lae_pkg::SEG_W + 1;
    localparam int STEP_PAD = lae_pkg::NUM_W - lae_pkg::STEP_W;
    localparam int PCT_PAD  = lae_pkg::NUM_W - 7;

    localparam logic [lae_pkg::STEP_W-1:0] FULL_SCALE = 17'h10000;
    localparam logic [TICK_WIDTH-1:0]      TICK_MAX   = {TICK_WIDTH{1'b1}};
    localparam logic [SINCE_W-1:0]         SINCE_MAX  = {SINCE_W{1'b1}};
    localparam logic [lae_pkg::SEG_W-1:0]  MS_PER_S   = 23'd1000;
    localparam logic [lae_pkg::SEG_W-1:0]  PCT_DEN    = 23'd100;
    localparam logic [6:0]                 PCT_MAX    = 7'd100;
    localparam logic [15:0]                UNIT_VEL   = 16'd256;

    localparam logic [lae_pkg::CNT_W-1:0] STEPS_TICK = lae_pkg::CNT_W'(lae_pkg::NUM_W);
    localparam logic [lae_pkg::CNT_W-1:0] STEPS_HOLD = lae_pkg::CNT_W'(7 + 16);
    localparam logic [lae_pkg::CNT_W-1:0] STEPS_STEP = lae_pkg::CNT_W'(lae_pkg::STEP_W);

    localparam logic [2:0] CFG_ATTACK  = 3'd0;
    localparam logic [2:0] CFG_DECAY   = 3'd1;
    localparam logic [2:0] CFG_SUSTAIN = 3'd2;
    localparam logic [2:0] CFG_RELEASE = 3'd3;
    localparam logic [2:0] CFG_MODE    = 3'd4;
    localparam logic [2:0] CFG_TPS     = 3'd5;

    localparam logic [1:0] PH_SILENT = 2'd0;
    localparam logic [1:0] PH_PLAY   = 2'd1;
    localparam logic [1:0] PH_REL    = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_TMUL, S_TDIV, S_HOLD, S_AINC, S_DDEC, S_RDEC,
        S_LCMP, S_LMUL, S_VSTART, S_VMUL, S_PUSH
    } t_state;

    typedef enum logic [1:0] {
        SEG_ATTACK, SEG_DECAY, SEG_RELEASE
    } t_seg;

    t_state r_state;
    t_seg   r_seg;

    // Configuration registers.
    logic [15:0] r_attack_ms;
    logic [15:0] r_decay_ms;
    logic [6:0]  r_sustain;
    logic [15:0] r_release_ms;
    logic        r_mode;
    logic [15:0] r_tps;

    // Envelope state.
    logic [1:0]                  r_phase;
    logic [TICK_WIDTH-1:0]       r_tick;
    logic [SINCE_W-1:0]          r_since;
    logic [15:0]                 r_prev;
    logic [lae_pkg::STEP_W-1:0]  r_level;
    logic [15:0]                 r_vel;
    logic [lae_pkg::SEG_W-1:0]   r_a_ticks;
    logic [lae_pkg::SEG_W-1:0]   r_d_ticks;
    logic [lae_pkg::SEG_W-1:0]   r_r_ticks;
    logic [lae_pkg::STEP_W-1:0]  r_a_inc;
    logic [lae_pkg::STEP_W-1:0]  r_d_dec;
    logic [lae_pkg::STEP_W-1:0]  r_r_dec;
    logic [lae_pkg::STEP_W-1:0]  r_hold;
    logic [23:0]                 r_scaled;

    // Arithmetic unit requests.
    logic                        r_mul_start;
    logic [lae_pkg::STEP_W-1:0]  r_mul_a;
    logic [lae_pkg::SEG_W-1:0]   r_mul_b;
    lae_pkg::t_div_req           r_div_req;
    logic [lae_pkg::NUM_W-1:0]   r_div_num;
    logic [lae_pkg::SEG_W-1:0]   r_div_den;

    // Output register.
    logic                        r_out_valid;
    logic [16:0]                 r_out_env;
    logic [23:0]                 r_out_scaled;
    logic [1:0]                  r_out_phase;

    logic                        w_mul_done;
    logic [lae_pkg::PROD_W-1:0]  w_mul_prod;
    logic                        w_div_done;
    logic [lae_pkg::NUM_W-1:0]   w_div_quo;

    logic                        w_change;
    logic                        w_start_note;
    logic                        w_release;
    logic [6:0]                  w_pct;
    logic [15:0]                 w_ms;
    logic                        w_tick_low;
    logic [SINCE_W-1:0]          w_t24;
    logic [SINCE_W-1:0]          w_ad_sum;
    logic [SINCE_W-1:0]          w_decay_t;
    logic                        w_in_attack;
    logic                        w_in_decay;
    logic                        w_in_release;
    logic [TICK_WIDTH-1:0]       n_tick;
    logic [SINCE_W-1:0]          n_since;

    lae_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_mul_start),
        .i_mcand   (r_mul_a),
        .i_mplier  (r_mul_b),
        .o_done    (w_mul_done),
        .o_product (w_mul_prod)
    );

    lae_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_div_req),
        .i_num   (r_div_num),
        .i_den   (r_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    assign w_change     = i_trigger_level != r_prev;
    assign w_release    = w_change && (i_trigger_level == '0);
    assign w_start_note = w_change && (i_trigger_level != '0) && (!r_mode || r_prev == '0);
    assign w_pct        = (r_sustain > PCT_MAX) ? PCT_MAX : r_sustain;

    always_comb begin
        case (r_seg)
            SEG_ATTACK: w_ms = r_attack_ms;
            SEG_DECAY:  w_ms = r_decay_ms;
            default:    w_ms = r_release_ms;
        endcase
    end

    // Segment boundaries fit in 24 bits; a larger tick count is past every boundary.
    assign w_tick_low   = r_tick <= TICK_WIDTH'(SINCE_MAX);
    assign w_t24        = r_tick[SINCE_W-1:0];
    assign w_ad_sum     = {1'b0, r_a_ticks} + {1'b0, r_d_ticks};
    assign w_decay_t    = w_t24 - {1'b0, r_a_ticks};
    assign w_in_attack  = w_tick_low && (w_t24 <= {1'b0, r_a_ticks});
    assign w_in_decay   = w_tick_low && (w_t24 <= w_ad_sum);
    assign w_in_release = r_since <= {1'b0, r_r_ticks};

    // The release counter advances when the tick counter does, until it saturates at its own maximum.
    assign n_tick  = (r_tick == TICK_MAX) ? r_tick : r_tick + TICK_WIDTH'(1);
    assign n_since = (r_tick != TICK_MAX && r_since != SINCE_MAX) ?
                     r_since + SINCE_W'(1) : r_since;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_seg        <= SEG_ATTACK;
            r_mul_start  <= 1'b0;
            r_div_req    <= '0;
            r_out_valid  <= 1'b0;
            r_attack_ms  <= '0;
            r_decay_ms   <= '0;
            r_sustain    <= PCT_MAX;
            r_release_ms <= '0;
            r_mode       <= 1'b0;
            r_tps        <= 16'd1000;
            r_phase      <= PH_SILENT;
            r_tick       <= '0;
            r_since      <= '0;
            r_prev       <= '0;
            r_level      <= '0;
            r_vel        <= '0;
            r_a_ticks    <= '0;
            r_d_ticks    <= '0;
            r_r_ticks    <= '0;
            r_a_inc      <= FULL_SCALE;
            r_d_dec      <= '0;
            r_r_dec      <= '0;
            r_hold       <= FULL_SCALE;
        end else begin
            r_mul_start     <= 1'b0;
            r_div_req.start <= 1'b0;

            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_ATTACK:  r_attack_ms  <= i_cfg_data;
                    CFG_DECAY:   r_decay_ms   <= i_cfg_data;
                    CFG_SUSTAIN: r_sustain    <= i_cfg_data[6:0];
                    CFG_RELEASE: r_release_ms <= i_cfg_data;
                    CFG_MODE:    r_mode       <= i_cfg_data[0];
                    CFG_TPS:     r_tps        <= i_cfg_data;
                    default: ;
                endcase
            end

            case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        if (w_change) begin
                            r_prev <= i_trigger_level;
                        end
                        if (w_start_note) begin
                            r_phase     <= PH_PLAY;
                            r_tick      <= '0;
                            r_vel       <= r_mode ? UNIT_VEL : i_trigger_level;
                            r_seg       <= SEG_ATTACK;
                            r_mul_start <= 1'b1;
                            r_mul_a     <= {1'b0, r_tps};
                            r_mul_b     <= {7'b0, r_attack_ms};
                            r_state     <= S_TMUL;
                        end else if (w_release) begin
                            r_phase <= PH_REL;
                            r_since <= '0;
                            r_hold  <= r_level;
                            if (r_r_ticks != '0) begin
                                r_div_req <= '{start: 1'b1, steps: STEPS_STEP};
                                r_div_num <= {r_level, {STEP_PAD{1'b0}}};
                                r_div_den <= r_r_ticks;
                            end
                            r_state <= S_RDEC;
                        end else begin
                            r_state <= S_LCMP;
                        end
                    end
                end

                S_TMUL: begin
                    if (w_mul_done) begin
                        r_div_req <= '{start: 1'b1, steps: STEPS_TICK};
                        r_div_num <= w_mul_prod[lae_pkg::NUM_W-1:0];
                        r_div_den <= MS_PER_S;
                        r_state   <= S_TDIV;
                    end
                end

                S_TDIV: begin
                    if (w_div_done) begin
                        case (r_seg)
                            SEG_ATTACK: begin
                                r_a_ticks   <= w_div_quo[lae_pkg::SEG_W-1:0];
                                r_seg       <= SEG_DECAY;
                                r_mul_start <= 1'b1;
                                r_mul_a     <= {1'b0, r_tps};
                                r_mul_b     <= {7'b0, r_decay_ms};
                                r_state     <= S_TMUL;
                            end
                            SEG_DECAY: begin
                                r_d_ticks   <= w_div_quo[lae_pkg::SEG_W-1:0];
                                r_seg       <= SEG_RELEASE;
                                r_mul_start <= 1'b1;
                                r_mul_a     <= {1'b0, r_tps};
                                r_mul_b     <= {7'b0, w_ms == r_decay_ms ? r_release_ms
                                                                         : r_release_ms};
                                r_state     <= S_TMUL;
                            end
                            default: begin
                                r_r_ticks <= w_div_quo[lae_pkg::SEG_W-1:0];
                                r_div_req <= '{start: 1'b1, steps: STEPS_HOLD};
                                r_div_num <= {w_pct, {PCT_PAD{1'b0}}};
                                r_div_den <= PCT_DEN;
                                r_state   <= S_HOLD;
                            end
                        endcase
                    end
                end

                S_HOLD: begin
                    if (w_div_done) begin
                        r_hold <= w_div_quo[lae_pkg::STEP_W-1:0];
                        if (r_a_ticks != '0) begin
                            r_div_req <= '{start: 1'b1, steps: STEPS_STEP};
                            r_div_num <= {FULL_SCALE, {STEP_PAD{1'b0}}};
                            r_div_den <= r_a_ticks;
                        end
                        r_state <= S_AINC;
                    end
                end

                // A zero-length segment takes the whole step at once and needs no division.
                S_AINC: begin
                    if (r_a_ticks == '0 || w_div_done) begin
                        r_a_inc <= (r_a_ticks == '0) ? FULL_SCALE
                                                     : w_div_quo[lae_pkg::STEP_W-1:0];
                        if (r_d_ticks != '0) begin
                            r_div_req <= '{start: 1'b1, steps: STEPS_STEP};
                            r_div_num <= {FULL_SCALE - r_hold, {STEP_PAD{1'b0}}};
                            r_div_den <= r_d_ticks;
                        end
                        r_state <= S_DDEC;
                    end
                end

                S_DDEC: begin
                    if (r_d_ticks == '0 || w_div_done) begin
                        r_d_dec <= (r_d_ticks == '0) ? FULL_SCALE - r_hold
                                                     : w_div_quo[lae_pkg::STEP_W-1:0];
                        r_state <= S_LCMP;
                    end
                end

                S_RDEC: begin
                    if (r_r_ticks == '0 || w_div_done) begin
                        r_r_dec <= (r_r_ticks == '0) ? r_hold
                                                     : w_div_quo[lae_pkg::STEP_W-1:0];
                        r_state <= S_LCMP;
                    end
                end

                S_LCMP: begin
                    r_tick  <= n_tick;
                    r_since <= n_since;
                    case (r_phase)
                        PH_PLAY: begin
                            if (w_in_attack) begin
                                r_seg       <= SEG_ATTACK;
                                r_mul_start <= 1'b1;
                                r_mul_a     <= r_a_inc;
                                r_mul_b     <= w_t24[lae_pkg::SEG_W-1:0];
                                r_state     <= S_LMUL;
                            end else if (w_in_decay) begin
                                r_seg       <= SEG_DECAY;
                                r_mul_start <= 1'b1;
                                r_mul_a     <= r_d_dec;
                                r_mul_b     <= w_decay_t[lae_pkg::SEG_W-1:0];
                                r_state     <= S_LMUL;
                            end else begin
                                r_level <= r_hold;
                                r_state <= S_VSTART;
                            end
                        end
                        PH_REL: begin
                            if (w_in_release) begin
                                r_seg       <= SEG_RELEASE;
                                r_mul_start <= 1'b1;
                                r_mul_a     <= r_r_dec;
                                r_mul_b     <= r_since[lae_pkg::SEG_W-1:0];
                                r_state     <= S_LMUL;
                            end else begin
                                r_level <= '0;
                                r_phase <= PH_SILENT;
                                r_state <= S_VSTART;
                            end
                        end
                        default: begin
                            r_state <= S_VSTART;
                        end
                    endcase
                end

                // Step sizes are truncated quotients, so no ramp product passes its segment span.
                S_LMUL: begin
                    if (w_mul_done) begin
                        case (r_seg)
                            SEG_ATTACK: r_level <= w_mul_prod[lae_pkg::STEP_W-1:0];
                            SEG_DECAY:  r_level <= FULL_SCALE - w_mul_prod[lae_pkg::STEP_W-1:0];
                            default:    r_level <= r_hold - w_mul_prod[lae_pkg::STEP_W-1:0];
                        endcase
                        r_state <= S_VSTART;
                    end
                end

                S_VSTART: begin
                    r_mul_start <= 1'b1;
                    r_mul_a     <= r_level;
                    r_mul_b     <= {7'b0, r_vel};
                    r_state     <= S_VMUL;
                end

                S_VMUL: begin
                    if (w_mul_done) begin
                        r_scaled <= w_mul_prod[31:8];
                        r_state  <= S_PUSH;
                    end
                end

                // The output register takes a new beat when it is empty or its previous beat is leaving.
                S_PUSH: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid  <= 1'b1;
                        r_out_env    <= r_level;
                        r_out_scaled <= r_scaled;
                        r_out_phase  <= r_phase;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall          = r_state != S_IDLE;
    assign o_valid          = r_out_valid;
    assign o_envelope_level = r_out_env;
    assign o_scaled_level   = r_out_scaled;
    assign o_phase          = r_out_phase;
    assign o_cfg_ready      = 1'b1;

    `LAE_ASSERT_IMPLY(a_quiet_prev, i_clk, i_rst_n, r_phase != PH_PLAY, r_prev == '0, "trigger memory nonzero outside a playing note")
    `LAE_ASSERT_ALWAYS(a_level_range, i_clk, i_rst_n, r_level <= FULL_SCALE, "envelope level above full scale")
    `LAE_ASSERT_NEXT(a_push_free, i_clk, i_rst_n, r_state == S_PUSH && !r_out_valid, r_out_valid && r_state == S_IDLE, "finished tick not moved into a free output register")

endmodule

>>> dv/tb_linear_adsr_envelope.sv
// Self-checking testbench for the linear ADSR envelope generator.
module tb_linear_adsr_envelope;
    import lae_pkg::*;

    localparam int TICK_W = 32;
    localparam int RANDOM_TICKS = 750;
    localparam logic [31:0] FULL_SCALE = 32'd65536;

    typedef enum logic [2:0] {
        REG_ATTACK_MS,
        REG_DECAY_MS,
        REG_SUSTAIN_PCT,
        REG_RELEASE_MS,
        REG_RETRIGGER_MODE,
        REG_TICKS_PER_SEC
    } reg_idx_e;

    typedef enum logic [1:0] {
        PH_SILENT,
        PH_PLAYING,
        PH_RELEASING
    } phase_e;

    typedef struct packed {
        logic [16:0] envelope;
        logic [23:0] scaled;
        phase_e      phase;
    } env_result_t;

    typedef enum logic {
        ROW_REG,
        ROW_TICK
    } row_kind_e;

    // A tick row carries the trigger level in value; a register row carries write data.
    typedef struct packed {
        row_kind_e   kind;
        reg_idx_e    reg_idx;
        logic [15:0] value;
        logic        known;
        env_result_t result;
    } dir_row_t;

    localparam env_result_t BLANK = '{17'd0, 24'd0, PH_SILENT};

    localparam int DIR_ROWS = 32;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // Reset settings: all segments are zero ticks long, full sustain.
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b1, '{17'd0, 24'd0, PH_SILENT}},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0100, 1'b1, '{17'd0, 24'd0, PH_PLAYING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0100, 1'b1, '{17'd65536, 24'd65536, PH_PLAYING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'hFFFF, 1'b1, '{17'd0, 24'd0, PH_PLAYING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'hFFFF, 1'b1, '{17'd65536, 24'd16776960, PH_PLAYING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b1, '{17'd65536, 24'd16776960, PH_RELEASING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b1, '{17'd0, 24'd0, PH_SILENT}},
        // Mode one, sustain above hundred and zero ticks per second.
        '{ROW_REG, REG_RETRIGGER_MODE, 16'd1, 1'b0, BLANK},
        '{ROW_REG, REG_SUSTAIN_PCT, 16'd127, 1'b0, BLANK},
        '{ROW_REG, REG_TICKS_PER_SEC, 16'd0, 1'b0, BLANK},
        '{ROW_REG, REG_ATTACK_MS, 16'hFFFF, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0080, 1'b1, '{17'd0, 24'd0, PH_PLAYING}},
        // A changed trigger while playing in mode one must not restart the note.
        '{ROW_TICK, REG_ATTACK_MS, 16'h0200, 1'b1, '{17'd65536, 24'd65536, PH_PLAYING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b1, '{17'd65536, 24'd65536, PH_RELEASING}},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b1, '{17'd0, 24'd0, PH_SILENT}},
        // Short ramps to zero sustain, with a retrigger in the decay.
        '{ROW_REG, REG_RETRIGGER_MODE, 16'd0, 1'b0, BLANK},
        '{ROW_REG, REG_SUSTAIN_PCT, 16'd0, 1'b0, BLANK},
        '{ROW_REG, REG_TICKS_PER_SEC, 16'd1000, 1'b0, BLANK},
        '{ROW_REG, REG_ATTACK_MS, 16'd3, 1'b0, BLANK},
        '{ROW_REG, REG_DECAY_MS, 16'd2, 1'b0, BLANK},
        '{ROW_REG, REG_RELEASE_MS, 16'd2, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h8000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h8000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h8000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h8000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h8000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0001, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0001, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b0, BLANK},
        '{ROW_TICK, REG_ATTACK_MS, 16'h0000, 1'b0, BLANK}
    };

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [15:0] i_trigger_level = '0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [16:0] o_envelope_level;
    logic [23:0] o_scaled_level;
    logic [1:0]  o_phase;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = '0;
    logic [15:0] i_cfg_data = '0;

    // Travels with each input beat: a typed-in expectation overrides the predictor.
    logic        tick_known = 1'b0;
    env_result_t tick_result = BLANK;

    int send_idle_pct = 37;
    int recv_idle_pct = 55;
    int failures = 0;
    int ticks_sent = 0;
    bit cfg_open = 1'b0;

    env_result_t expected_levels [$];

    // Register copies.
    logic [15:0] cfg_attack, cfg_decay, cfg_release, cfg_tps;
    logic [6:0]  cfg_sustain;
    logic        cfg_mode;

    // Envelope state.
    phase_e            env_phase;
    logic [TICK_W-1:0] tick_cnt, rel_origin;
    logic [15:0]       last_trig, cur_vel;
    logic [16:0]       cur_level, hold_lvl;
    logic [SEG_W-1:0]  atk_len, dec_len, rel_len;
    logic [STEP_W-1:0] atk_step, dec_step, rel_step;

    linear_adsr_envelope #(
        .TICK_WIDTH(TICK_W)
    ) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_trigger_level (i_trigger_level),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_envelope_level(o_envelope_level),
        .o_scaled_level  (o_scaled_level),
        .o_phase         (o_phase),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("[linear_adsr_envelope] ERROR");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    function automatic logic [SEG_W-1:0] seg_ticks(input logic [15:0] ms,
                                                   input logic [15:0] tps);
        logic [31:0] prod;
        prod = 32'(ms) * 32'(tps);
        return SEG_W'(prod / 32'd1000);
    endfunction

    // Samples the registers that a note start uses.
    function automatic void latch_note();
        logic [6:0] pct;
        pct = (cfg_sustain > 7'd100) ? 7'd100 : cfg_sustain;
        cur_vel = cfg_mode ? 16'd256 : last_trig;
        atk_len = seg_ticks(cfg_attack, cfg_tps);
        dec_len = seg_ticks(cfg_decay, cfg_tps);
        rel_len = seg_ticks(cfg_release, cfg_tps);
        hold_lvl = 17'((32'(pct) << 16) / 32'd100);
        atk_step = (atk_len != 0) ? STEP_W'(FULL_SCALE / 32'(atk_len)) : STEP_W'(FULL_SCALE);
        dec_step = (dec_len != 0) ? STEP_W'((FULL_SCALE - 32'(hold_lvl)) / 32'(dec_len))
                                  : STEP_W'(FULL_SCALE - 32'(hold_lvl));
    endfunction

    function automatic void reset_model();
        cfg_attack = '0;
        cfg_decay = '0;
        cfg_sustain = 7'd100;
        cfg_release = '0;
        cfg_mode = 1'b0;
        cfg_tps = 16'd1000;
        env_phase = PH_SILENT;
        tick_cnt = '0;
        last_trig = '0;
        cur_level = '0;
        rel_origin = '0;
        rel_step = '0;
        latch_note();
    endfunction

    function automatic void load_reg(input logic [2:0] idx, input logic [15:0] data);
        case (idx)
            REG_ATTACK_MS:      cfg_attack = data;
            REG_DECAY_MS:       cfg_decay = data;
            REG_SUSTAIN_PCT:    cfg_sustain = data[6:0];
            REG_RELEASE_MS:     cfg_release = data;
            REG_RETRIGGER_MODE: cfg_mode = data[0];
            REG_TICKS_PER_SEC:  cfg_tps = data;
            default: ;
        endcase
    endfunction

    function automatic env_result_t advance_envelope(input logic [15:0] trig);
        env_result_t res;
        longint unsigned t, a, d, drop, since, lvl;
        if (trig != last_trig) begin
            if (trig == 16'd0) begin
                rel_origin = tick_cnt;
                env_phase = PH_RELEASING;
                hold_lvl = cur_level;
                rel_step = (rel_len != 0) ? STEP_W'(32'(hold_lvl) / 32'(rel_len)) : hold_lvl;
            end else if (!cfg_mode || last_trig == 16'd0) begin
                last_trig = trig;
                latch_note();
                env_phase = PH_PLAYING;
                tick_cnt = '0;
            end
            last_trig = trig;
        end

        t = 64'(tick_cnt);
        a = 64'(atk_len);
        d = 64'(dec_len);
        lvl = 64'(cur_level);
        if (env_phase == PH_PLAYING) begin
            if (t <= a) begin
                lvl = t * 64'(atk_step);
            end else if (t <= a + d) begin
                drop = (t - a) * 64'(dec_step);
                lvl = (drop >= 64'(FULL_SCALE)) ? 64'd0 : 64'(FULL_SCALE) - drop;
            end else begin
                lvl = 64'(hold_lvl);
            end
        end else if (env_phase == PH_RELEASING) begin
            since = (t >= 64'(rel_origin)) ? t - 64'(rel_origin) : 64'd0;
            if (since <= 64'(rel_len)) begin
                drop = since * 64'(rel_step);
                lvl = (drop >= 64'(hold_lvl)) ? 64'd0 : 64'(hold_lvl) - drop;
            end else begin
                lvl = 64'd0;
                env_phase = PH_SILENT;
            end
        end
        if (lvl > 64'(FULL_SCALE)) lvl = 64'(FULL_SCALE);
        cur_level = 17'(lvl);

        if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;

        res.envelope = cur_level;
        res.scaled = 24'((64'(cur_level) * 64'(cur_vel)) >> 8);
        res.phase = env_phase;
        return res;
    endfunction

    always @(posedge i_clk) begin : scoreboard
        env_result_t predicted, want;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) load_reg(i_cfg_index, i_cfg_data);
            if (i_valid && !o_stall) begin
                predicted = advance_envelope(i_trigger_level);
                expected_levels.push_back(tick_known ? tick_result : predicted);
            end
            if (o_valid && !i_stall) begin
                if (expected_levels.size() == 0) begin
                    $error("result beat with no tick outstanding: envelope_level %0d",
                           o_envelope_level);
                    failures++;
                end else begin
                    want = expected_levels.pop_front();
                    if (o_envelope_level !== want.envelope) begin
                        $error("envelope_level: expected %0d, actual %0d",
                               want.envelope, o_envelope_level);
                        failures++;
                    end
                    if (o_scaled_level !== want.scaled) begin
                        $error("scaled_level: expected %0d, actual %0d",
                               want.scaled, o_scaled_level);
                        failures++;
                    end
                    if (o_phase !== want.phase) begin
                        $error("phase: expected %0d, actual %0d", want.phase, o_phase);
                        failures++;
                    end
                end
            end
        end
    end

    // Holds the input side off until every outstanding result beat has come back.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(negedge i_clk);
        while (expected_levels.size() != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    // Consecutive writes keep valid high; the next tick beat lowers it.
    task automatic write_reg(input reg_idx_e idx, input logic [15:0] data);
        if (!cfg_open) begin
            drain_results();
            cfg_open = 1'b1;
        end
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
    endtask

    task automatic send_trigger(input logic [15:0] trig, input logic known,
                                input env_result_t result);
        if (cfg_open) begin
            i_cfg_valid <= 1'b0;
            cfg_open = 1'b0;
        end
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_trigger_level <= trig;
        tick_known <= known;
        tick_result <= result;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic logic [15:0] pick_trigger();
        case ($urandom_range(9))
            0: return 16'hFFFF;
            1: return 16'h0001;
            2: return 16'h0100;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic int capped_ticks(input logic [15:0] ms, input logic [15:0] tps);
        int n;
        n = int'(seg_ticks(ms, tps));
        return (n > 60) ? 60 : n;
    endfunction

    task automatic random_tick(input logic [15:0] trig);
        if (ticks_sent < RANDOM_TICKS / 3) begin
            send_idle_pct = 37;
            recv_idle_pct = 55;
        end else if (ticks_sent < 2 * RANDOM_TICKS / 3) begin
            send_idle_pct = 55;
            recv_idle_pct = 37;
        end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
        end
        if (ticks_sent == RANDOM_TICKS / 2 || $urandom_range(199) == 0) drain_results();
        send_trigger(trig, 1'b0, BLANK);
        ticks_sent++;
    endtask

    task automatic random_phase(input int idx);
        logic [15:0] tps, a_ms, d_ms, r_ms, vel;
        logic [6:0]  sus;
        logic        mode;
        int          span, a_len, d_len, r_len, n, stop;
        if (idx == 0) begin
            tps = 16'hFFFF;
            a_ms = 16'hFFFF;
            d_ms = 16'hFFFF;
            r_ms = 16'hFFFF;
            sus = 7'd100;
            mode = 1'b0;
        end else if (idx == 1) begin
            tps = 16'd1;
            a_ms = 16'd0;
            d_ms = 16'd0;
            r_ms = 16'd0;
            sus = 7'd0;
            mode = 1'b1;
        end else begin
            case ($urandom_range(3))
                0: tps = 16'($urandom_range(1, 20));
                1: tps = 16'd1000;
                2: tps = 16'($urandom_range(0, 65535));
                default: tps = 16'($urandom_range(100, 5000));
            endcase
            // Keep segments to a few dozen ticks so that every phase is reached.
            span = (tps == 16'd0) ? 65535 : 40000 / int'(tps);
            if (span == 0) span = 1;
            a_ms = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(0, span));
            d_ms = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(0, span));
            r_ms = ($urandom_range(4) == 0) ? 16'd0 : 16'($urandom_range(0, span));
            sus = 7'($urandom_range(0, 127));
            mode = 1'($urandom_range(1));
        end

        write_reg(REG_ATTACK_MS, a_ms);
        write_reg(REG_DECAY_MS, d_ms);
        write_reg(REG_SUSTAIN_PCT, 16'(sus));
        write_reg(REG_RELEASE_MS, r_ms);
        write_reg(REG_RETRIGGER_MODE, 16'(mode));
        write_reg(REG_TICKS_PER_SEC, tps);

        a_len = capped_ticks(a_ms, tps);
        d_len = capped_ticks(d_ms, tps);
        r_len = capped_ticks(r_ms, tps);
        stop = ticks_sent + ((idx == 0) ? 20 : $urandom_range(40, 90));

        while (ticks_sent < stop) begin
            if ($urandom_range(99) < 80) begin
                // A whole note: held for a random number of ticks up to past its ramps, then released.
                vel = pick_trigger();
                n = $urandom_range(1, a_len + d_len + 8);
                for (int k = 0; k < n; k++) begin
                    if (k != 0 && $urandom_range(99) < 4) vel = pick_trigger();
                    random_tick(vel);
                end
                n = $urandom_range(1, r_len + 6);
                for (int k = 0; k < n; k++) random_tick(16'h0000);
            end else begin
                n = $urandom_range(1, 8);
                for (int k = 0; k < n; k++)
                    random_tick(($urandom_range(1) != 0) ? pick_trigger() : 16'h0000);
            end
        end
    endtask

    initial begin : stimulus
        int phase_no;
        phase_no = 0;
        reset_model();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < DIR_ROWS; r++) begin
            if (DIRECTED[r].kind == ROW_REG)
                write_reg(DIRECTED[r].reg_idx, DIRECTED[r].value);
            else
                send_trigger(DIRECTED[r].value, DIRECTED[r].known, DIRECTED[r].result);
        end

        while (ticks_sent < RANDOM_TICKS) begin
            random_phase(phase_no);
            phase_no++;
        end

        drain_results();
        repeat (300) @(posedge i_clk);
        if (failures == 0)
            $display("[linear_adsr_envelope] OK");
        else
            $display("[linear_adsr_envelope] ERROR");
        $finish;
    end

endmodule
